// File: rtl/lmb_pkg.sv
// lmb_pkg: shared types and constants of the level meter ballistics block
// item kinds, queue entry layout, register indexes and the log2 fraction function
// no dependencies
package lmb_pkg;

   localparam int POS_W = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // 20*log10(2)/60 in Q0.16
   localparam logic [12:0] DB_PER_LOG2_Q16 = 13'd6576;

   typedef enum logic [1:0] {
      FUNC_LEVEL = 2'd0,
      FUNC_PEAK  = 2'd1,
      FUNC_TICK  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      CSR_RISE_COEF      = 3'd0,
      CSR_FALL_COEF      = 3'd1,
      CSR_DECAY_COEF     = 3'd2,
      CSR_HOLD_TICKS     = 3'd3,
      CSR_PEAK_DROP_COEF = 3'd4
   } csr_index_type;

   typedef struct packed {
      func_type           kind;
      logic [POS_W-1:0]   position;
   } item_type;

   // floor(log2(1 + i / 2^tab_bits) * 65536) by repeated squaring in Q2.30
   function automatic logic [15:0] log2_frac(input int unsigned tab_bits,
                                             input int unsigned i);
      logic [63:0] y;
      logic [15:0] r;
      int          k;
      y = (64'd1 << 30) + (64'(i) << (30 - tab_bits));
      r = '0;
      for (k = 15; k >= 0; k--) begin
         y = (y * y) >> 30;
         if (y >= (64'd2 << 30)) begin
            y = y >> 1;
            r[k] = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

// File: rtl/level_meter_ballistics.sv
// level_meter_ballistics: top level of the audio level meter with peak hold
// ties the converting front, the item queue and the ballistics back together
// depends on lmb_pkg, lmb_front, lmb_queue, lmb_back
//
//   group   direction  handshake               payload
//   req_    in         req_tvalid/req_tready   tdata magnitude, tuser func
//   rsp_    out        rsp_tvalid/rsp_tready   tdata meter_position, peak_position
//   csr_    in         csr_wr_en               csr_index, csr_wdata
//
// one item per cycle sustained while no held result stalls a tick; front pipeline
// of two register stages (priority encode, then table lookup with the dB multiply)
// feeds a four-entry queue; a tick popped at the back is written straight into
// the result register, after the two front stages and the queue
// reset is synchronous; it clears all meter state and loads default coefficients
// a held result stalls only ticks at the queue head; req_tready drops once the
// items in the front stages and queue fill the queue depth
module level_meter_ballistics #(
   parameter int LOG_TABLE_BITS = 6,
   parameter int SAMPLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input transactions
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] magnitude
   input  logic [1:0]  req_tuser,    // [1:0] func
   // result transactions, one per tick
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [15:0] meter_position, [31:16] peak_position
   // register writes
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // front to queue
   logic                         push;
   lmb_pkg::item_type            push_item;
   logic [lmb_pkg::QCNT_W-1:0]   q_count;

   // queue to back
   logic                         head_valid;
   lmb_pkg::item_type            head_item;
   logic                         pop;

   // conversion of level and peak magnitudes to meter positions
   lmb_front #(
      .LOG_TABLE_BITS (LOG_TABLE_BITS),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_count    (q_count),
      .push       (push),
      .push_item  (push_item)
   );

   // decouples conversion from the ballistics update
   lmb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .count      (q_count)
   );

   // meter state, registers and result register
   lmb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/lmb_front.sv
// lmb_front: accepts items, converts magnitudes to meter positions
// two register stages: priority encode, then table lookup and dB scaling
// depends on lmb_pkg
module lmb_front #(
   parameter int LOG_TABLE_BITS = 6,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,
   input  logic [1:0]                       req_tuser,
   input  logic [lmb_pkg::QCNT_W-1:0]       q_count,
   output logic                             push,
   output lmb_pkg::item_type                push_item
);

   localparam int TAB = 1 << LOG_TABLE_BITS;
   localparam int EW = $clog2(SAMPLE_BITS);
   localparam int DW = $clog2(SAMPLE_BITS + 1) + 16;
   localparam int PW = DW + 13;
   localparam logic [DW-1:0] FULL_Q16 = DW'(SAMPLE_BITS) << 16;

   logic [15:0]                  rom [TAB];
   logic                         accept;
   logic                         known_func;
   logic [SAMPLE_BITS-1:0]       mag;
   logic [EW-1:0]                msb;
   logic [SAMPLE_BITS+LOG_TABLE_BITS-1:0] norm;
   logic [lmb_pkg::QCNT_W-1:0]   in_flight;

   logic                         vld_a_ff, vld_a_in;
   lmb_pkg::func_type            kind_a_ff;
   logic                         zero_a_ff;
   logic [EW-1:0]                msb_a_ff;
   logic [LOG_TABLE_BITS-1:0]    idx_a_ff;

   logic                         vld_b_ff, vld_b_in;
   lmb_pkg::func_type            kind_b_ff;
   logic                         zero_b_ff;
   logic [DW-1:0]                deficit;
   logic [PW-1:0]                prod_b_ff, prod_b_in;
   logic [15:0]                  drop_lo;
   logic [15:0]                  position;

   for (genvar g = 0; g < TAB; g++) begin : g_rom
      assign rom[g] = lmb_pkg::log2_frac(LOG_TABLE_BITS, g);
   end

   // credit: everything in flight must fit in the queue
   assign in_flight = lmb_pkg::QCNT_W'(vld_a_ff) + lmb_pkg::QCNT_W'(vld_b_ff) + q_count;
   assign req_tready = (in_flight < lmb_pkg::QCNT_W'(lmb_pkg::QUEUE_DEPTH));
   assign accept = req_tvalid && req_tready;
   assign known_func = (req_tuser == lmb_pkg::FUNC_LEVEL) || (req_tuser == lmb_pkg::FUNC_PEAK)
                    || (req_tuser == lmb_pkg::FUNC_TICK);
   assign vld_a_in = accept && known_func;

   assign mag = SAMPLE_BITS'(req_tdata);

   always_comb begin
      msb = '0;
      for (int t = 0; t < SAMPLE_BITS; t++) begin
         if (mag[t]) begin
            msb = EW'(t);
         end
      end
   end

   assign norm = {mag, {LOG_TABLE_BITS{1'b0}}} << (EW'(SAMPLE_BITS - 1) - msb);

   // deficit below full scale in Q16 log2 units, then scaled to positions
   assign deficit = FULL_Q16 - DW'({msb_a_ff, rom[idx_a_ff]});
   assign prod_b_in = PW'(deficit) * PW'(lmb_pkg::DB_PER_LOG2_Q16) + PW'(32768);
   assign vld_b_in = vld_a_ff;

   assign drop_lo = prod_b_ff[31:16];
   always_comb begin
      if (zero_b_ff || (|prod_b_ff[PW-1:32])) begin
         position = '0;
      end else if (drop_lo == 16'd0) begin
         position = 16'hFFFF;
      end else begin
         position = 16'(17'h10000 - 17'(drop_lo));
      end
   end

   assign push = vld_b_ff;
   assign push_item.kind = kind_b_ff;
   assign push_item.position = position;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         vld_a_ff <= vld_a_in;
         vld_b_ff <= vld_b_in;
      end
      kind_a_ff <= lmb_pkg::func_type'(req_tuser);
      zero_a_ff <= (mag == '0);
      msb_a_ff  <= msb;
      idx_a_ff  <= norm[SAMPLE_BITS+LOG_TABLE_BITS-2 -: LOG_TABLE_BITS];
      kind_b_ff <= kind_a_ff;
      zero_b_ff <= zero_a_ff;
      prod_b_ff <= prod_b_in;
   end

endmodule

// File: rtl/lmb_queue.sv
// lmb_queue: short fifo of converted items between front and back
// register array with one read place at the head
// depends on lmb_pkg
module lmb_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  lmb_pkg::item_type                push_item,
   input  logic                             pop,
   output logic                             head_valid,
   output lmb_pkg::item_type                head_item,
   output logic [lmb_pkg::QCNT_W-1:0]       count
);

   lmb_pkg::item_type             mem_ff [lmb_pkg::QUEUE_DEPTH];
   logic [lmb_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [lmb_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [lmb_pkg::QCNT_W-1:0]    count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + lmb_pkg::QCNT_W'(push) - lmb_pkg::QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < lmb_pkg::QCNT_W'(lmb_pkg::QUEUE_DEPTH)) || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

endmodule

// File: rtl/lmb_back.sv
// lmb_back: meter state, configuration registers and result register
// stores targets, runs smoothing, peak hold and decay once per tick
// depends on lmb_pkg
module lmb_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  lmb_pkg::item_type                head_item,
   output logic                             pop,
   input  logic                             csr_wr_en,
   input  logic [2:0]                       csr_index,
   input  logic [15:0]                      csr_wdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata
);

   logic [15:0]  rise_coef_ff, fall_coef_ff, decay_coef_ff, peak_drop_coef_ff;
   logic [7:0]   hold_ticks_ff;

   logic [15:0]  target_level_ff, target_level_in;
   logic [15:0]  target_peak_ff, target_peak_in;
   logic [15:0]  smoothed_ff, smoothed_in;
   logic [15:0]  shown_peak_ff, shown_peak_in;
   logic [7:0]   hold_left_ff, hold_left_in;
   logic         rsp_vld_ff, rsp_vld_in;
   logic [31:0]  rsp_data_ff, rsp_data_in;

   logic         out_free;
   logic         is_tick;
   logic         tick_go;
   logic [15:0]  coef;
   logic [16:0]  coef_inv;
   logic [33:0]  acc;
   logic [31:0]  peak_scaled, level_decayed, peak_decayed;

   assign out_free = !rsp_vld_ff || rsp_tready;
   assign is_tick  = (head_item.kind == lmb_pkg::FUNC_TICK);
   assign pop      = head_valid && (!is_tick || out_free);
   assign tick_go  = pop && is_tick;

   assign coef     = (target_level_ff > smoothed_ff) ? rise_coef_ff : fall_coef_ff;
   assign coef_inv = 17'h10000 - 17'(coef);
   assign acc      = 34'(smoothed_ff) * 34'(coef) + 34'(target_level_ff) * 34'(coef_inv);
   assign peak_scaled   = shown_peak_ff * peak_drop_coef_ff;
   assign level_decayed = target_level_ff * decay_coef_ff;
   assign peak_decayed  = target_peak_ff * decay_coef_ff;

   always_comb begin
      target_level_in = target_level_ff;
      target_peak_in  = target_peak_ff;
      smoothed_in     = smoothed_ff;
      shown_peak_in   = shown_peak_ff;
      hold_left_in    = hold_left_ff;
      if (pop) begin
         case (head_item.kind)
            lmb_pkg::FUNC_LEVEL: begin
               target_level_in = head_item.position;
            end
            lmb_pkg::FUNC_PEAK: begin
               target_peak_in = head_item.position;
            end
            lmb_pkg::FUNC_TICK: begin
               smoothed_in = acc[31:16];
               if (target_peak_ff > shown_peak_ff) begin
                  shown_peak_in = target_peak_ff;
                  hold_left_in  = hold_ticks_ff;
               end else if (hold_left_ff != 8'd0) begin
                  hold_left_in = hold_left_ff - 8'd1;
               end else begin
                  shown_peak_in = peak_scaled[31:16];
               end
               target_level_in = level_decayed[31:16];
               target_peak_in  = peak_decayed[31:16];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      if (tick_go) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = {shown_peak_in, smoothed_in};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_coef_ff      <= 16'd58982;
         fall_coef_ff      <= 16'd62259;
         decay_coef_ff     <= 16'd62259;
         hold_ticks_ff     <= 8'd30;
         peak_drop_coef_ff <= 16'd64881;
         target_level_ff   <= '0;
         target_peak_ff    <= '0;
         smoothed_ff       <= '0;
         shown_peak_ff     <= '0;
         hold_left_ff      <= '0;
         rsp_vld_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               lmb_pkg::CSR_RISE_COEF:      rise_coef_ff      <= csr_wdata;
               lmb_pkg::CSR_FALL_COEF:      fall_coef_ff      <= csr_wdata;
               lmb_pkg::CSR_DECAY_COEF:     decay_coef_ff     <= csr_wdata;
               lmb_pkg::CSR_HOLD_TICKS:     hold_ticks_ff     <= csr_wdata[7:0];
               lmb_pkg::CSR_PEAK_DROP_COEF: peak_drop_coef_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         target_level_ff <= target_level_in;
         target_peak_ff  <= target_peak_in;
         smoothed_ff     <= smoothed_in;
         shown_peak_ff   <= shown_peak_in;
         hold_left_ff    <= hold_left_in;
         rsp_vld_ff      <= rsp_vld_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   a_smooth_upper: assert property (@(posedge clock) disable iff (reset)
      tick_go |=> (smoothed_ff <= $past(smoothed_ff)) || (smoothed_ff <= $past(target_level_ff)))
      else $error("smoothed level overshoots");

   a_smooth_lower: assert property (@(posedge clock) disable iff (reset)
      tick_go |=> (smoothed_ff >= $past(smoothed_ff)) || (smoothed_ff >= $past(target_level_ff)))
      else $error("smoothed level undershoots");

   a_peak_held: assert property (@(posedge clock) disable iff (reset)
      tick_go && (hold_left_ff != 8'd0) && !(target_peak_ff > shown_peak_ff)
      |=> $stable(shown_peak_ff))
      else $error("shown peak moved during hold");

endmodule
